/* src/ssil_pkg.sv */
// Shared types and request/status codes for the sorted series interpolating lookup.
`default_nettype none
package ssil_pkg;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [62:0]        sample_time;
    logic signed [63:0] sample_value;
    logic [11:0]        sample_index;
    logic [62:0]        query_time;
  } ssil_in_t;

  typedef struct packed {
    logic [62:0]        result_time;
    logic signed [63:0] result_value;
    logic [1:0]         status;
    logic [12:0]        sample_count;
  } ssil_out_t;

endpackage
`default_nettype wire

/* src/sorted_series_interpolating_lookup.sv */
// Top level: sample table in two memories, binary search, interpolation unit.
//
//   channel | ports                      | transfer
//   input   | start, busy, in_item       | start high while busy low
//   result  | out_valid, out_item        | one cycle, out_valid high
//
// Clear and append go straight to the result state; read passes through S_RD
// first. A query runs the search probes (log2 of the fill count plus one
// probes at most), the neighbor reads in S_N0 to S_N2, the multiply in S_MUL and
// S_MUL2 and the 128 steps of the restoring divider; end-point queries skip to S_FIN.
// Reset is synchronous and active low and empties the table. The receiver
// cannot stall; busy stays high until the result has been shown.
`default_nettype none
module sorted_series_interpolating_lookup #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ssil_pkg::ssil_in_t in_item,
  output logic                    out_valid,
  output ssil_pkg::ssil_out_t     out_item
);
  import ssil_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_PROBE = 4'd2, S_PWAIT = 4'd3,
                         S_N0 = 4'd4, S_N1 = 4'd5, S_N2 = 4'd6, S_MUL = 4'd7,
                         S_MUL2 = 4'd8, S_DIV = 4'd9, S_FIN = 4'd10, S_DONE = 4'd11;

  // Sample memories.
  logic [62:0] time_mem [TABLE_DEPTH];
  logic [63:0] value_mem [TABLE_DEPTH];
  logic [62:0] t_rd;
  logic [63:0] v_rd;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [62:0] wtime;
  logic [63:0] wvalue;

  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr]  <= wtime;
      value_mem[waddr] <= wvalue;
    end
    t_rd <= time_mem[raddr];
    v_rd <= value_mem[raddr];
  end

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  ssil_in_t      req_r, req_nxt;
  ssil_out_t     res_r, res_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [62:0]   t0_r, t0_nxt, t1_r, t1_nxt;
  logic [63:0]   v0_r, v0_nxt, v1_r, v1_nxt;
  logic [62:0]   num_r, num_nxt, den_r, den_nxt;
  logic [63:0]   mag_r, mag_nxt;
  logic          up_r, up_nxt;
  logic [63:0]   pp_r [4];
  logic [63:0]   pp_nxt [4];
  logic [127:0]  prod_r, prod_nxt;
  logic [63:0]   rem_r, rem_nxt, quo_r, quo_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [CW-1:0] mid;
  logic [64:0]   rem_sh;
  logic [127:0]  mid_sum;

  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign rem_sh = {rem_r, prod_r[127]};
  assign mid_sum = {pp_r[3], 64'd0} + {32'd0, pp_r[1], 32'd0}
                 + {32'd0, pp_r[2], 32'd0} + {64'd0, pp_r[0]};

  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; req_nxt = req_r; res_nxt = res_r;
    lo_nxt = lo_r; hi_nxt = hi_r; t0_nxt = t0_r; t1_nxt = t1_r; v0_nxt = v0_r;
    v1_nxt = v1_r; num_nxt = num_r; den_nxt = den_r; mag_nxt = mag_r; up_nxt = up_r;
    pp_nxt = pp_r; prod_nxt = prod_r; rem_nxt = rem_r; quo_nxt = quo_r; cnt_nxt = cnt_r;
    we = 1'b0; waddr = fill_r[AW-1:0]; wtime = req_r.sample_time;
    wvalue = req_r.sample_value; raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_item;
          res_nxt = '0;
          state_nxt = S_DONE;
          unique case (in_item.req_type)
            REQ_CLEAR: fill_nxt = '0;
            REQ_APPEND: begin
              if (fill_r >= CW'(TABLE_DEPTH)) res_nxt.status = ST_FULL;
              else begin
                we = 1'b1; wtime = in_item.sample_time;
                wvalue = in_item.sample_value; fill_nxt = fill_r + 1'b1;
              end
            end
            REQ_READ: begin
              if (32'(in_item.sample_index) >= 32'(fill_r))
                res_nxt.status = ST_EMPTY;
              else begin
                raddr = AW'(in_item.sample_index); state_nxt = S_RD;
              end
            end
            default: begin
              if (fill_r == '0) res_nxt.status = ST_EMPTY;
              else begin
                lo_nxt = '0; hi_nxt = fill_r; state_nxt = S_PROBE;
              end
            end
          endcase
        end
      end
      S_RD: begin
        // Memory data for a read by index.
        res_nxt.result_time  = t_rd;
        res_nxt.result_value = v_rd;
        state_nxt = S_DONE;
      end
      S_PROBE: begin
        if (lo_r < hi_r) begin
          raddr = mid[AW-1:0]; state_nxt = S_PWAIT;
        end else if (lo_r == fill_r) begin
          raddr = AW'(fill_r - 1'b1); state_nxt = S_FIN; cnt_nxt = 7'd0;
        end else if (lo_r == '0) begin
          raddr = '0; state_nxt = S_FIN; cnt_nxt = 7'd0;
        end else begin
          raddr = AW'(lo_r - 1'b1); state_nxt = S_N0;
        end
      end
      S_PWAIT: begin
        if (t_rd < req_r.query_time) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
        state_nxt = S_PROBE;
      end
      S_N0: begin
        // Lower neighbor is on the read port; fetch the upper one.
        t0_nxt = t_rd; v0_nxt = v_rd;
        raddr = lo_r[AW-1:0]; state_nxt = S_N1;
      end
      S_N1: begin
        raddr = lo_r[AW-1:0]; state_nxt = S_N2;
      end
      S_N2: begin
        t1_nxt = t_rd; v1_nxt = v_rd;
        den_nxt = t_rd - t0_r;
        if (req_r.query_time <= t0_r) num_nxt = '0;
        else if (req_r.query_time >= t_rd) num_nxt = t_rd - t0_r;
        else num_nxt = req_r.query_time - t0_r;
        up_nxt = ({~v_rd[63], v_rd[62:0]} >= {~v0_r[63], v0_r[62:0]});
        mag_nxt = up_nxt ? (v_rd - v0_r) : (v0_r - v_rd);
        if (t_rd <= t0_r) begin
          res_nxt.result_value = v0_r; state_nxt = S_DONE;
        end else state_nxt = S_MUL;
      end
      S_MUL: begin
        pp_nxt[0] = {32'd0, num_r[31:0]} * {32'd0, mag_r[31:0]};
        pp_nxt[1] = {32'd0, num_r[31:0]} * {32'd0, mag_r[63:32]};
        pp_nxt[2] = {33'd0, num_r[62:32]} * {32'd0, mag_r[31:0]};
        pp_nxt[3] = {33'd0, num_r[62:32]} * {32'd0, mag_r[63:32]};
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        prod_nxt = mid_sum; rem_nxt = '0; quo_nxt = '0; cnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // One restoring divide step per cycle.
        if (rem_sh >= {2'd0, den_r}) begin
          rem_nxt = 64'(rem_sh - {2'd0, den_r}); quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[63:0]; quo_nxt = {quo_r[62:0], 1'b0};
        end
        prod_nxt = {prod_r[126:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 7'd127) state_nxt = S_DONE;
        if (cnt_r == 7'd127)
          res_nxt.result_value = up_r ? (v0_r + quo_nxt) : (v0_r - quo_nxt);
      end
      S_FIN: begin
        // Memory data for an end-point query.
        res_nxt.result_value = v_rd;
        if (cnt_r == 7'd1) res_nxt.result_time = t_rd;
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
    req_r <= req_nxt; res_r <= res_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    t0_r <= t0_nxt; t1_r <= t1_nxt; v0_r <= v0_nxt; v1_r <= v1_nxt;
    num_r <= num_nxt; den_r <= den_nxt; mag_r <= mag_nxt; up_r <= up_nxt;
    pp_r <= pp_nxt; prod_r <= prod_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  // Result drives.
  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  always_comb begin
    out_item = res_r;
    out_item.sample_count = 13'(fill_r);
  end

endmodule
`default_nettype wire

/* src/ssil_checker.sv */
// Port-level checker for the lookup, bound to the top level.
`default_nettype none
module ssil_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire ssil_pkg::ssil_out_t out_item
);
  import ssil_pkg::*;

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_busy_then: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transfer not followed by busy");
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status != 2'd3)) else $error("bad status code");
  a_empty_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_EMPTY) |-> (out_item.result_value == '0))
    else $error("empty status with nonzero value");
endmodule

bind sorted_series_interpolating_lookup ssil_checker u_ssil_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
`default_nettype wire

/* tb/sv/sorted_series_interpolating_lookup_test.sv */
// Self-checking testbench for the sorted series interpolating lookup.
`timescale 1ns / 1ps
module sorted_series_interpolating_lookup_test;
  import ssil_pkg::*;

  localparam int DEPTH = 4096;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ssil_in_t in_item = '0;
  logic out_valid;
  ssil_out_t out_item;

  always #1 clk = ~clk;

  sorted_series_interpolating_lookup #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // Predictor state: a private copy of the sample table.
  logic [62:0] pred_times[DEPTH];
  logic [63:0] pred_values[DEPTH];
  int unsigned pred_fill;

  ssil_in_t pending_items[$];
  ssil_out_t expected_results[$];
  int fail_count = 0;
  int unsigned cycle_count = 0;
  bit drain_request = 1'b0;

  // Interpolate between entries idx-1 and idx, truncating toward v0.
  function automatic logic [63:0] interpolate_value(logic [62:0] q, int unsigned idx);
    logic [62:0] t0, t1;
    logic [63:0] v0, v1, mag, den, num;
    logic [127:0] prod;
    logic [127:0] step;
    bit up;
    t0 = pred_times[idx-1];
    t1 = pred_times[idx];
    v0 = pred_values[idx-1];
    v1 = pred_values[idx];
    if (t1 <= t0) return v0;
    den = {1'b0, t1 - t0};
    if (q <= t0) num = 0;
    else if (q >= t1) num = den;
    else num = {1'b0, q - t0};
    up = $signed(v1) >= $signed(v0);
    mag = up ? v1 - v0 : v0 - v1;
    prod = 128'(num) * 128'(mag);
    step = prod / 128'(den);
    return up ? v0 + step[63:0] : v0 - step[63:0];
  endfunction

  // Compute the result of one transfer and update the table copy.
  function automatic ssil_out_t predict_lookup(ssil_in_t it);
    ssil_out_t r;
    int unsigned lo, hi, mid;
    r = '0;
    case (it.req_type)
      REQ_CLEAR: pred_fill = 0;
      REQ_APPEND: begin
        if (pred_fill >= DEPTH) r.status = ST_FULL;
        else begin
          pred_times[pred_fill] = it.sample_time;
          pred_values[pred_fill] = it.sample_value;
          pred_fill++;
        end
      end
      REQ_READ: begin
        if (it.sample_index >= pred_fill) r.status = ST_EMPTY;
        else begin
          r.result_time = pred_times[it.sample_index];
          r.result_value = pred_values[it.sample_index];
        end
      end
      default: begin
        if (pred_fill == 0) r.status = ST_EMPTY;
        else begin
          lo = 0;
          hi = pred_fill;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (pred_times[mid] < it.query_time) lo = mid + 1;
            else hi = mid;
          end
          if (lo == pred_fill) r.result_value = pred_values[pred_fill-1];
          else if (lo == 0) r.result_value = pred_values[0];
          else r.result_value = interpolate_value(it.query_time, lo);
        end
      end
    endcase
    r.sample_count = 13'(pred_fill);
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic ssil_in_t make_item(logic [1:0] kind, logic [62:0] t,
                                         logic [63:0] v, logic [11:0] ix,
                                         logic [62:0] q);
    ssil_in_t it;
    it.req_type = kind;
    it.sample_time = t;
    it.sample_value = v;
    it.sample_index = ix;
    it.query_time = q;
    return it;
  endfunction

  // Add one item at the tail of the pending queue.
  function automatic void enqueue(ssil_in_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // Short gap, occasionally a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: presents queued items; a drain request holds off until all results are in.
  int gap_left = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.insert(expected_results.size(), predict_lookup(in_item));
        void'(pending_items.pop_front());
        gap_left = pick_gap();
      end
      if (start && busy) begin
        // Hold the current item until the block accepts it.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (drain_request && (expected_results.size() != 0 || busy ||
                   (start && !busy))) begin
        start <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drain_request <= 1'b0;
        start <= 1'b1;
        in_item <= pending_items[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compares each result transfer with the oldest expectation.
  always @(posedge clk) begin
    ssil_out_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.result_time !== out_item.result_time)
          $display("%0t: result_time expected %h actual %h", $time,
                   exp_r.result_time, out_item.result_time);
        if (exp_r.result_value !== out_item.result_value)
          $display("%0t: result_value expected %h actual %h", $time,
                   exp_r.result_value, out_item.result_value);
        if (exp_r.status !== out_item.status)
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_r.status, out_item.status);
        if (exp_r.sample_count !== out_item.sample_count)
          $display("%0t: sample_count expected %0d actual %0d", $time,
                   exp_r.sample_count, out_item.sample_count);
        if (exp_r !== out_item) fail_count++;
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** sorted_series_interpolating_lookup: FAILED **");
      $finish;
    end
  end

  // Stimulus: directed cases, then random runs of mostly sorted tables.
  initial begin
    logic [62:0] t;
    logic [62:0] tq;
    int n, k, fill_model;
    enqueue(make_item(REQ_QUERY, '0, '0, '0, '1));
    enqueue(make_item(REQ_READ, '0, '0, '0, '0));
    enqueue(make_item(REQ_APPEND, 63'd100, 64'h8000_0000_0000_0000, '0, '0));
    enqueue(make_item(REQ_APPEND, 63'd100, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0));
    enqueue(make_item(REQ_APPEND, 63'd300, 64'h8000_0000_0000_0000, '0, '0));
    enqueue(make_item(REQ_APPEND, 63'd50, 64'h0000_0001_0000_0000, '0, '0));
    enqueue(make_item(REQ_APPEND, 63'h7FFF_FFFF_FFFF_FFFF,
                      64'h7FFF_FFFF_FFFF_FFFF, '0, '0));
    enqueue(make_item(REQ_QUERY, '0, '0, '0, 63'd0));
    enqueue(make_item(REQ_QUERY, '0, '0, '0, 63'd100));
    enqueue(make_item(REQ_QUERY, '0, '0, '0, 63'd200));
    enqueue(make_item(REQ_QUERY, '0, '0, '0, 63'd299));
    enqueue(make_item(REQ_QUERY, '0, '0, '0, 63'h4000_0000_0000_0000));
    enqueue(make_item(REQ_QUERY, '0, '0, '0, '1));
    enqueue(make_item(REQ_READ, '0, '0, 12'd4, '0));
    enqueue(make_item(REQ_READ, '0, '0, 12'd5, '0));
    enqueue(make_item(REQ_READ, '0, '0, 12'hFFF, '0));
    enqueue(make_item(REQ_CLEAR, '1, '1, '1, '1));
    enqueue(make_item(REQ_READ, '0, '0, 12'd0, '0));
    enqueue(make_item(REQ_QUERY, '0, '0, '0, 63'd5));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Random part: mostly sorted tables with reads and queries.
    n = 0;
    fill_model = 0;
    t = '0;
    while (n < 528) begin
      k = $urandom_range(0, 99);
      if (k < 6) begin
        enqueue(make_item(REQ_CLEAR, 63'(rand64()), rand64(), 12'($urandom),
                          63'(rand64())));
        fill_model = 0;
        t = 63'($urandom_range(0, 1000));
      end else if (k < 45) begin
        if ($urandom_range(0, 9) == 0) t = 63'(rand64());
        else if ($urandom_range(0, 5) != 0)
          t = t + (($urandom_range(0, 3) == 0) ? 63'(rand64() >> $urandom_range(2, 40))
                                               : 63'($urandom_range(1, 5000)));
        enqueue(make_item(REQ_APPEND, t, rand64(), 12'($urandom), 63'(rand64())));
        fill_model++;
      end else if (k < 60) begin
        enqueue(make_item(REQ_READ, 63'(rand64()), rand64(),
          ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, fill_model)),
          63'(rand64())));
      end else begin
        tq = ($urandom_range(0, 4) == 0) ? 63'(rand64())
                                         : t - 63'($urandom_range(0, 20000));
        enqueue(make_item(REQ_QUERY, 63'(rand64()), rand64(), 12'($urandom), tq));
      end
      n++;
      if (n == 250) begin
        while (pending_items.size() != 0) @(posedge clk);
        drain_request <= 1'b1;
        @(posedge clk);
      end
    end

    // A few closing reads and queries on the last table.
    enqueue(make_item(REQ_READ, '0, '0, 12'hFFF, '0));
    enqueue(make_item(REQ_QUERY, '0, '0, '0, 63'd7000));
    enqueue(make_item(REQ_QUERY, '0, '0, '0, '1));

    while (pending_items.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("** sorted_series_interpolating_lookup: PASSED **");
    end else begin
      $display("** sorted_series_interpolating_lookup: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
src/ssil_pkg.sv
src/sorted_series_interpolating_lookup.sv
src/ssil_checker.sv
tb/sv/sorted_series_interpolating_lookup_test.sv
